// File: sv/ttc_pkg.sv
// Shared types and codes for the text tokenizer.
package ttc_pkg;

  // Width of the line number carried on every result
  localparam int unsigned LineOutW = 24;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_CHAR  = 2'd0,
    KIND_END   = 2'd1,
    KIND_EOI   = 2'd2,
    KIND_ERROR = 2'd3
  } kind_e;

  // Token types carried on a token end
  typedef enum logic [1:0] {
    TOK_IDENT  = 2'd0,
    TOK_VALUE  = 2'd1,
    TOK_STRING = 2'd2,
    TOK_NONE   = 2'd3
  } tok_e;

  // Scanner state, one-hot
  typedef enum logic [3:0] {
    MODE_IDLE    = 4'b0001,
    MODE_WORD    = 4'b0010,
    MODE_STRING  = 4'b0100,
    MODE_COMMENT = 4'b1000
  } mode_e;

  // Special bytes
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChLowE  = 8'h65;
  localparam logic [7:0] ChUpE   = 8'h45;

  // One result
  typedef struct packed {
    kind_e                kind;
    logic [7:0]           char_out;
    logic                 starts_token;
    logic [1:0]           token_kind;
    logic [LineOutW-1:0]  line_number;
    logic                 is_last;
  } res_t;

endpackage

// File: sv/text_tokenizer_with_comments.sv
// Streaming byte tokenizer with '#' comments, quoted strings and line counting.
// A byte is accepted into the input register; its results then load into the
//   result buffer. Throughput: one result per cycle while out_stall_i is low;
//   bytes that give no result (spaces, comments) flow at one per cycle.
// The three-entry result buffer sets the rate: a byte expands only once it is
//   empty or its last entry is being taken. Reset (asynchronous) empties both
//   stages and returns the scanner to between tokens at line 1.
module text_tokenizer_with_comments #(
  parameter int unsigned LINE_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    text_byte_i,
  input  logic                          is_final_i,
  // Result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    kind_o,
  output logic [7:0]                    char_out_o,
  output logic                          starts_token_o,
  output logic [1:0]                    token_kind_o,
  output logic [ttc_pkg::LineOutW-1:0]  line_number_o,
  output logic                          is_last_o
);
  import ttc_pkg::*;

  // Input register
  logic       in_vld_q;
  logic [7:0] byte_q;
  logic       fin_q;

  // Scanner state
  mode_e                mode_q, mode_d;
  logic                 num_q, num_d;
  logic                 first_q, first_d;
  logic [LINE_BITS-1:0] lc_q, lc_d;

  // Result buffer, slot 0 is presented
  res_t       res_q [3];
  res_t       res_d [3];
  logic [1:0] cnt_q;
  logic [1:0] n_new;

  logic in_fire, out_fire, load_ok, expand;

  function automatic logic is_value_char(logic [7:0] c);
    return (c >= ChZero && c <= ChNine) || c == ChPlus || c == ChMinus ||
           c == ChDot || c == ChLowE || c == ChUpE;
  endfunction

  function automatic logic is_num_start(logic [7:0] c);
    return (c >= ChZero && c <= ChNine) || c == ChPlus || c == ChMinus || c == ChDot;
  endfunction

  // Handshakes
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_fire    = out_valid_o && !out_stall_i;
  assign load_ok     = (cnt_q == 2'd0) || (cnt_q == 2'd1 && !out_stall_i);
  assign expand      = in_vld_q && load_ok;
  assign in_stall_o  = in_vld_q && !load_ok;
  assign in_fire     = in_valid_i && !in_stall_o;

  // Line count as seen on the result port
  logic [LINE_BITS+LineOutW-1:0] lc_old_w, lc_new_w;
  assign lc_old_w = {{LineOutW{1'b0}}, lc_q};
  assign lc_new_w = {{LineOutW{1'b0}}, lc_d};

  // Byte classes
  logic is_ws, is_lf, is_delim;
  assign is_ws    = (byte_q == ChSpace) || (byte_q == ChTab) || (byte_q == ChCr);
  assign is_lf    = (byte_q == ChLf);
  assign is_delim = is_ws || is_lf;

  // Per-byte scan: at most one main result, then up to two end-of-text results
  logic  m_vld, f0_vld, f1_vld, count_lf;
  res_t  m_res, f0_res, f1_res;
  mode_e mode_n;
  logic  num_n, first_n;

  always_comb begin
    mode_n   = mode_q;
    num_n    = num_q;
    first_n  = first_q;
    count_lf = 1'b0;
    m_vld    = 1'b0;
    m_res    = '{kind: KIND_CHAR, char_out: byte_q, starts_token: 1'b0,
                 token_kind: TOK_IDENT, line_number: lc_old_w[LineOutW-1:0],
                 is_last: 1'b0};
    unique case (mode_q)
      MODE_IDLE: begin
        if (is_lf) begin
          count_lf = 1'b1;
        end else if (byte_q == ChHash) begin
          mode_n = MODE_COMMENT;
        end else if (byte_q == ChQuote) begin
          mode_n  = MODE_STRING;
          first_n = 1'b1;
        end else if (!is_ws) begin
          mode_n             = MODE_WORD;
          num_n              = is_num_start(byte_q);
          m_vld              = 1'b1;
          m_res.starts_token = 1'b1;
        end
      end
      MODE_WORD: begin
        m_vld = 1'b1;
        if (is_delim) begin
          m_res.kind       = KIND_END;
          m_res.char_out   = 8'd0;
          m_res.token_kind = num_q ? TOK_VALUE : TOK_IDENT;
          mode_n           = MODE_IDLE;
          num_n            = 1'b0;
          count_lf         = is_lf;
        end else if (!is_value_char(byte_q)) begin
          num_n = 1'b0;
        end
      end
      MODE_STRING: begin
        m_vld   = 1'b1;
        first_n = 1'b0;
        if (byte_q == ChQuote) begin
          m_res.kind       = KIND_END;
          m_res.char_out   = 8'd0;
          m_res.token_kind = TOK_STRING;
          mode_n           = MODE_IDLE;
        end else begin
          m_res.starts_token = first_q;
        end
      end
      MODE_COMMENT: begin
        if (is_lf) begin
          count_lf = 1'b1;
          mode_n   = MODE_IDLE;
        end
      end
      default: begin
        mode_n = MODE_IDLE;
      end
    endcase

    // Saturating line count
    lc_d = (count_lf && lc_q != {LINE_BITS{1'b1}}) ? lc_q + LINE_BITS'(1) : lc_q;

    // End of text
    f0_vld = 1'b0;
    f1_vld = 1'b0;
    f0_res = '{kind: KIND_EOI, char_out: 8'd0, starts_token: 1'b0,
               token_kind: TOK_IDENT, line_number: lc_new_w[LineOutW-1:0],
               is_last: 1'b0};
    f1_res = f0_res;
    if (fin_q) begin
      f0_vld = 1'b1;
      if (mode_n == MODE_STRING) begin
        f0_res.kind = KIND_ERROR;
      end else if (mode_n == MODE_WORD) begin
        f0_res.kind       = KIND_END;
        f0_res.token_kind = num_n ? TOK_VALUE : TOK_IDENT;
        f1_vld            = 1'b1;
      end
    end

    // Next state, back to reset values after the last byte
    mode_d  = fin_q ? MODE_IDLE : mode_n;
    num_d   = fin_q ? 1'b0 : num_n;
    first_d = fin_q ? 1'b0 : first_n;
  end

  // Pack the results into slots and mark the last one
  always_comb begin
    n_new = {1'b0, m_vld} + {1'b0, f0_vld} + {1'b0, f1_vld};
    if (m_vld) begin
      res_d[0] = m_res;
      res_d[1] = f0_res;
      res_d[2] = f1_res;
    end else begin
      res_d[0] = f0_res;
      res_d[1] = f1_res;
      res_d[2] = f1_res;
    end
    for (int i = 0; i < 3; i++) begin
      res_d[i].is_last = (n_new == 2'(i + 1));
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_fire) begin
      in_vld_q <= 1'b1;
    end else if (expand) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      byte_q <= text_byte_i;
      fin_q  <= is_final_i;
    end
  end

  // Scanner state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      num_q   <= 1'b0;
      first_q <= 1'b0;
      lc_q    <= LINE_BITS'(1);
    end else if (expand) begin
      mode_q  <= mode_d;
      num_q   <= num_d;
      first_q <= first_d;
      lc_q    <= fin_q ? LINE_BITS'(1) : lc_d;
    end
  end

  // Result buffer count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (expand) begin
      cnt_q <= n_new;
    end else if (out_fire) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  // Result buffer payload, shifts towards slot 0
  always_ff @(posedge clk_i) begin
    if (expand) begin
      res_q <= res_d;
    end else if (out_fire) begin
      res_q[0] <= res_q[1];
      res_q[1] <= res_q[2];
    end
  end

  assign kind_o         = res_q[0].kind;
  assign char_out_o     = res_q[0].char_out;
  assign starts_token_o = res_q[0].starts_token;
  assign token_kind_o   = res_q[0].token_kind;
  assign line_number_o  = res_q[0].line_number;
  assign is_last_o      = res_q[0].is_last;

endmodule

// File: sv/ttc_checker.sv
// Port-level checks for the text tokenizer, bound to the top level.
module ttc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic [7:0]                    text_byte_i,
  input logic                          is_final_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [1:0]                    kind_o,
  input logic [7:0]                    char_out_o,
  input logic                          starts_token_o,
  input logic [1:0]                    token_kind_o,
  input logic [ttc_pkg::LineOutW-1:0]  line_number_o,
  input logic                          is_last_o
);
  import ttc_pkg::*;

  // A stalled request keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) &&
      $stable(char_out_o) && $stable(line_number_o) && $stable(is_last_o))
    else $error("result changed while stalled");

  // Only token characters carry a byte or a token start
  a_char_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != KIND_CHAR |-> char_out_o == 8'd0 && !starts_token_o)
    else $error("byte or start flag on a non-character result");

  // Token type only on a token end, and never the unused code
  a_tok_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (kind_o == KIND_END ? token_kind_o != TOK_NONE
                                        : token_kind_o == TOK_IDENT))
    else $error("bad token type");

  // End of input and string errors close the results of their byte
  a_eoi_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_EOI || kind_o == KIND_ERROR) |-> is_last_o)
    else $error("end of text result not marked last");

  // Line numbers start at one
  a_line_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> line_number_o != '0)
    else $error("line number zero");

endmodule

bind text_tokenizer_with_comments ttc_checker u_ttc_checker (.*);

// File: sim/tb_text_tokenizer_with_comments.sv
// Self-checking testbench for the streaming text tokenizer.
module tb_text_tokenizer_with_comments;
  timeunit 1ns;
  timeprecision 1ps;

  import ttc_pkg::*;

  localparam int unsigned LineBits   = 24;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned TailCycles = 8;
  localparam string       ValueSet   = "+-0123456789.eE";

  // Predicts tokenizer results from accepted bytes and checks them in order
  class token_ledger;
    res_t                owed_q[$];
    int unsigned         errors;
    mode_e               mode;
    logic                numeric;
    logic                opening;
    logic [LineBits-1:0] lines;

    function new();
      errors = 0;
      clear_scan();
    endfunction

    function void clear_scan();
      mode    = MODE_IDLE;
      numeric = 1'b0;
      opening = 1'b0;
      lines   = 1;
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction

    function bit is_gap(logic [7:0] c);
      return c == ChSpace || c == ChTab || c == ChCr;
    endfunction

    function bit value_lead(logic [7:0] c);
      return (c >= ChZero && c <= ChNine) || c == ChPlus || c == ChMinus || c == ChDot;
    endfunction

    function bit value_char(logic [7:0] c);
      return value_lead(c) || c == ChLowE || c == ChUpE;
    endfunction

    function void bump_line();
      if (lines != {LineBits{1'b1}}) lines++;
    endfunction

    function void owe(kind_e k, logic [7:0] ch, logic first, tok_e tk);
      res_t r;
      r.kind         = k;
      r.char_out     = ch;
      r.starts_token = first;
      r.token_kind   = tk;
      r.line_number  = LineOutW'(lines);
      r.is_last      = 1'b0;
      owed_q.push_back(r);
    endfunction

    // Byte seen while no token is open
    function void between_tokens(logic [7:0] c);
      if (c == ChLf) begin
        bump_line();
      end else if (c == ChHash) begin
        mode = MODE_COMMENT;
      end else if (c == ChQuote) begin
        mode    = MODE_STRING;
        opening = 1'b1;
      end else if (!is_gap(c)) begin
        mode    = MODE_WORD;
        numeric = value_lead(c);
        owe(KIND_CHAR, c, 1'b1, TOK_IDENT);
      end
    endfunction

    function void note_byte(logic [7:0] c, logic fin);
      int unsigned base;
      base = owed_q.size();
      case (mode)
        MODE_IDLE: between_tokens(c);
        MODE_WORD: begin
          if (is_gap(c) || c == ChLf) begin
            // token end carries the line before a closing LF is counted
            owe(KIND_END, 8'h00, 1'b0, numeric ? TOK_VALUE : TOK_IDENT);
            mode    = MODE_IDLE;
            numeric = 1'b0;
            between_tokens(c);
          end else begin
            if (!value_char(c)) numeric = 1'b0;
            owe(KIND_CHAR, c, 1'b0, TOK_IDENT);
          end
        end
        MODE_STRING: begin
          if (c == ChQuote) begin
            owe(KIND_END, 8'h00, 1'b0, TOK_STRING);
            mode    = MODE_IDLE;
            opening = 1'b0;
          end else begin
            owe(KIND_CHAR, c, opening, TOK_IDENT);
            opening = 1'b0;
          end
        end
        default: begin
          if (c == ChLf) begin
            bump_line();
            mode = MODE_IDLE;
          end
        end
      endcase
      // end of text: close what is open, then start over at line 1
      if (fin) begin
        if (mode == MODE_STRING) begin
          owe(KIND_ERROR, 8'h00, 1'b0, TOK_IDENT);
        end else begin
          if (mode == MODE_WORD) owe(KIND_END, 8'h00, 1'b0, numeric ? TOK_VALUE : TOK_IDENT);
          owe(KIND_EOI, 8'h00, 1'b0, TOK_IDENT);
        end
        clear_scan();
      end
      if (owed_q.size() > base) owed_q[owed_q.size() - 1].is_last = 1'b1;
    endfunction

    function void compare(string what, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (owed_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got kind %0d char %02h",
                 $time, got.kind, got.char_out);
        return;
      end
      want = owed_q.pop_front();
      compare("kind", want.kind, got.kind);
      compare("char_out", want.char_out, got.char_out);
      compare("starts_token", want.starts_token, got.starts_token);
      compare("token_kind", want.token_kind, got.token_kind);
      compare("line_number", want.line_number, got.line_number);
      compare("is_last", want.is_last, got.is_last);
    endfunction
  endclass

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic [7:0]          text_byte = 8'h00;
  logic                is_final  = 1'b0;
  logic                out_stall = 1'b0;
  logic                in_stall;
  logic                out_valid;
  logic [1:0]          kind;
  logic [7:0]          char_out;
  logic                starts_token;
  logic [1:0]          token_kind;
  logic [LineOutW-1:0] line_number;
  logic                is_last;

  int unsigned idle_pct   = 0;
  int unsigned stall_pct  = 0;
  logic        hold_on    = 1'b0;
  int unsigned cycle_count = 0;
  logic [7:0]  draft_q[$];
  res_t        seen;
  token_ledger ledger = new();

  text_tokenizer_with_comments #(
    .LINE_BITS(LineBits)
  ) dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .text_byte_i   (text_byte),
    .is_final_i    (is_final),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .kind_o        (kind),
    .char_out_o    (char_out),
    .starts_token_o(starts_token),
    .token_kind_o  (token_kind),
    .line_number_o (line_number),
    .is_last_o     (is_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver back-pressure: random, or held for a long stretch
  always @(negedge clk) begin
    out_stall <= hold_on || ($urandom_range(99) < stall_pct);
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen.kind         = kind_e'(kind);
      seen.char_out     = char_out;
      seen.starts_token = starts_token;
      seen.token_kind   = token_kind;
      seen.line_number  = line_number;
      seen.is_last      = is_last;
      ledger.check_result(seen);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb_text_tokenizer_with_comments: done, errors");
      $finish;
    end
  end

  // Offer one byte, with random gaps ahead of it, and wait for acceptance
  task automatic send_byte(logic [7:0] b, logic fin);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    text_byte <= b;
    is_final  <= fin;
    do @(posedge clk); while (in_stall);
    ledger.note_byte(b, fin);
  endtask

  task automatic send_string(string s, bit fin);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], fin && (i == s.len() - 1));
  endtask

  task automatic send_draft();
    foreach (draft_q[i]) send_byte(draft_q[i], i == draft_q.size() - 1);
  endtask

  // Stop offering and wait for every owed result
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] word_byte(bit lead);
    logic [7:0] c;
    do c = 8'($urandom);
    while (c == ChSpace || c == ChTab || c == ChCr || c == ChLf ||
           (lead && (c == ChHash || c == ChQuote)));
    return c;
  endfunction

  function automatic logic [7:0] gap_byte();
    case ($urandom_range(3))
      0: return ChSpace;
      1: return ChTab;
      2: return ChCr;
      default: return ChLf;
    endcase
  endfunction

  // One text: mostly well-formed tokens, some noise, some cut short
  function automatic void build_text();
    logic [7:0] c;
    draft_q.delete();
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 8)) draft_q.push_back(8'($urandom));
      return;
    end
    repeat ($urandom_range(1, 6)) begin
      case ($urandom_range(4))
        0: begin
          draft_q.push_back(ValueSet[$urandom_range(12)]);
          repeat ($urandom_range(0, 5)) draft_q.push_back(ValueSet[$urandom_range(14)]);
          // now and then spoil the value with a stray non-blank byte
          if ($urandom_range(3) == 0) draft_q.push_back(word_byte(1'b0));
        end
        1, 4: begin
          draft_q.push_back(word_byte(1'b1));
          repeat ($urandom_range(0, 5)) draft_q.push_back(word_byte(1'b0));
        end
        2: begin
          draft_q.push_back(ChQuote);
          repeat ($urandom_range(0, 6)) begin
            do c = 8'($urandom); while (c == ChQuote);
            if ($urandom_range(5) == 0) c = ChLf;
            draft_q.push_back(c);
          end
          draft_q.push_back(ChQuote);
        end
        default: begin
          draft_q.push_back(ChHash);
          repeat ($urandom_range(0, 5)) begin
            do c = 8'($urandom); while (c == ChLf);
            draft_q.push_back(c);
          end
          draft_q.push_back(ChLf);
        end
      endcase
      repeat ($urandom_range(1, 2)) draft_q.push_back(gap_byte());
    end
    if ($urandom_range(4) == 0) draft_q = draft_q[0:$urandom_range(draft_q.size() - 1)];
  endfunction

  task automatic random_texts(int unsigned budget);
    int unsigned sent;
    sent = 0;
    while (sent < budget) begin
      build_text();
      send_draft();
      sent += draft_q.size();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: extreme bytes, numeric and identifier words, strings, comments,
    // and the end of text in each scanner state
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(ChTab, 1'b0);
    send_string("-.5e\n", 1'b0);
    send_string("9#\"\015", 1'b0);
    send_string("\"\"\"\n\"", 1'b0);
    send_string("#x\n", 1'b0);
    send_string("a", 1'b1);
    send_string("\"q", 1'b1);
    send_string("#", 1'b1);
    send_string(" ", 1'b1);
    settle();

    // Slow receiver
    idle_pct  = 14;
    stall_pct = 79;
    random_texts(140);

    // Long hold-off at the output while a long word keeps arriving
    fork
      begin
        hold_on = 1'b1;
        repeat (150) @(posedge clk);
        hold_on = 1'b0;
      end
    join_none
    draft_q.delete();
    draft_q.push_back(word_byte(1'b1));
    repeat (47) draft_q.push_back(word_byte(1'b0));
    draft_q.push_back(ChSpace);
    send_draft();
    settle();

    // Slow sender
    idle_pct  = 79;
    stall_pct = 14;
    random_texts(140);
    settle();

    // Full rate both ways
    idle_pct  = 0;
    stall_pct = 0;
    random_texts(140);
    settle();

    repeat (TailCycles) @(posedge clk);
    if (ledger.errors == 0) begin
      $display("tb_text_tokenizer_with_comments: done, clean");
    end else begin
      $display("tb_text_tokenizer_with_comments: done, errors");
    end
    $finish;
  end

endmodule
